// ----- src/tksu_pkg.sv -----
// ----------------------------------------------------------------------------
// tksu_pkg: shared constants for the streaming top-k selector
// Field widths and the reset value of the count register.
// ----------------------------------------------------------------------------
package tksu_pkg;

	localparam int VALUE_W = 31;
	localparam int RANK_W  = 4;
	localparam int CFG_W   = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage

// ----- src/tksu_insert.sv -----
// ----------------------------------------------------------------------------
// tksu_insert: sorted store with parallel insert
// Keeps the largest values of the current set in descending order and hands
// the updated store to the drain bank when the last value of a set arrives.
// ----------------------------------------------------------------------------
module tksu_insert #(
	parameter int TOP_K = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_fire,
	input  logic [tksu_pkg::VALUE_W-1:0]               value,
	input  logic                                       last,
	input  logic [tksu_pkg::CFG_W-1:0]                 count,
	output logic                                       load,
	output logic [$clog2(TOP_K+1)-1:0]                 load_count,
	output logic [TOP_K-1:0][tksu_pkg::VALUE_W-1:0]    load_data
);
	import tksu_pkg::*;

	localparam int CW = $clog2(TOP_K + 1);
	localparam int KW = (CW > CFG_W) ? CW : CFG_W;

	logic [TOP_K-1:0][VALUE_W-1:0] kept_q;
	logic [TOP_K-1:0][VALUE_W-1:0] nxt;
	logic [CW-1:0]                 held_q;
	logic [KW-1:0]                 cnt_ext;
	logic [KW-1:0]                 k;
	logic [KW-1:0]                 held_ext;
	logic [KW-1:0]                 h;
	logic [KW-1:0]                 new_h;
	logic [TOP_K-1:0]              ge;
	logic                          reject;

	always_comb begin
		cnt_ext = KW'(count);
		if (cnt_ext == '0) begin
			k = KW'(1);
		end else if (cnt_ext > KW'(TOP_K)) begin
			k = KW'(TOP_K);
		end else begin
			k = cnt_ext;
		end

		// drop surplus entries when the count was lowered mid-set
		held_ext = KW'(held_q);
		h = (held_ext > k) ? k : held_ext;

		for (int i = 0; i < TOP_K; i++) begin
			ge[i] = (KW'(i) < h) && (kept_q[i] >= value);
		end

		// store full and every kept value at least as large: no insert
		reject = 1'b0;
		for (int i = 0; i < TOP_K; i++) begin
			if (KW'(i) == k - KW'(1)) begin
				reject = ge[i];
			end
		end

		nxt[0] = ge[0] ? kept_q[0] : value;
		for (int i = 1; i < TOP_K; i++) begin
			if (ge[i]) begin
				nxt[i] = kept_q[i];
			end else if (ge[i-1]) begin
				nxt[i] = value;
			end else begin
				nxt[i] = kept_q[i-1];
			end
		end

		if (reject) begin
			new_h = h;
		end else if (h < k) begin
			new_h = h + KW'(1);
		end else begin
			new_h = h;
		end
	end

	assign load       = in_fire && last;
	assign load_count = CW'(new_h);
	assign load_data  = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (in_fire) begin
			held_q <= last ? '0 : CW'(new_h);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kept_q <= nxt;
		end
	end

endmodule

// ----- src/tksu_drain.sv -----
// ----------------------------------------------------------------------------
// tksu_drain: result bank and emitter
// Holds one finished set and shifts it out largest first, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module tksu_drain #(
	parameter int TOP_K = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       load,
	input  logic [$clog2(TOP_K+1)-1:0]                 load_count,
	input  logic [TOP_K-1:0][tksu_pkg::VALUE_W-1:0]    load_data,
	input  logic                                       out_stall,
	output logic                                       out_valid,
	output logic [tksu_pkg::VALUE_W-1:0]               ranked_value,
	output logic [tksu_pkg::RANK_W-1:0]                rank,
	output logic                                       final_res,
	output logic                                       busy
);
	import tksu_pkg::*;

	localparam int CW = $clog2(TOP_K + 1);

	logic [TOP_K-1:0][VALUE_W-1:0] bank_q;
	logic [CW-1:0]                 left_q;
	logic [RANK_W-1:0]             rank_q;
	logic                          busy_q;
	logic                          fire;
	logic                          done;

	assign fire         = busy_q && !out_stall;
	// the bank frees at the edge that delivers the final transaction
	assign done         = fire && (left_q == CW'(1));
	assign out_valid    = busy_q;
	assign busy         = busy_q && !done;
	assign ranked_value = bank_q[0];
	assign rank         = rank_q;
	assign final_res    = (left_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
			rank_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			left_q <= load_count;
			rank_q <= '0;
		end else if (fire) begin
			left_q <= left_q - CW'(1);
			rank_q <= rank_q + RANK_W'(1);
			if (left_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// advance the bank by one entry per delivered transaction
	always_ff @(posedge clk) begin
		if (load) begin
			bank_q <= load_data;
		end else if (fire) begin
			for (int i = 0; i < TOP_K - 1; i++) begin
				bank_q[i] <= bank_q[i+1];
			end
		end
	end

endmodule

// ----- src/streaming_top_k_selector_unit.sv -----
// ----------------------------------------------------------------------------
// streaming_top_k_selector_unit: streaming top-k selection
// Latency: the first result shows the cycle after the last value is taken.
// Throughput: one value, one result per cycle unless stalled; n per set.
// A last value waits until the final result of the previous set is taken.
// Reset clears the held count, the drain state and sets the count to 16.
// ----------------------------------------------------------------------------
module streaming_top_k_selector_unit #(
	parameter int TOP_K = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tksu_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tksu_pkg::VALUE_W-1:0]     value,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tksu_pkg::VALUE_W-1:0]     ranked_value,
	output logic [tksu_pkg::RANK_W-1:0]      rank,
	output logic                             final_res
);
	import tksu_pkg::*;

	localparam int CW = $clog2(TOP_K + 1);

	logic [CFG_W-1:0]              count_q;
	logic                          in_fire;
	logic                          load;
	logic [CW-1:0]                 load_count;
	logic [TOP_K-1:0][VALUE_W-1:0] load_data;
	logic                          busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CFG_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// hold a last value until the drain bank is free
	assign in_stall = last && busy;
	assign in_fire  = in_valid && !in_stall;

	tksu_insert #(.TOP_K(TOP_K)) u_insert (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.value      (value),
		.last       (last),
		.count      (count_q),
		.load       (load),
		.load_count (load_count),
		.load_data  (load_data)
	);

	tksu_drain #(.TOP_K(TOP_K)) u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.load_count   (load_count),
		.load_data    (load_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.ranked_value (ranked_value),
		.rank         (rank),
		.final_res    (final_res),
		.busy         (busy)
	);

endmodule

// ----- src/tksu_checker.sv -----
// ----------------------------------------------------------------------------
// tksu_checker: port-level checks for the top-k selector
// Watches the output run of each set as seen on the top level's ports.
// ----------------------------------------------------------------------------
module tksu_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             last,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [tksu_pkg::VALUE_W-1:0]     ranked_value,
	input  logic [tksu_pkg::RANK_W-1:0]      rank,
	input  logic                             final_res
);
	import tksu_pkg::*;

	logic out_fire;
	logic in_last_fire;

	assign out_fire     = out_valid && !out_stall;
	assign in_last_fire = in_valid && !in_stall && last;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ranked_value) && $stable(rank))
		else $error("stalled result changed");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !final_res |=> out_valid)
		else $error("result run broke before its final transaction");

	a_rank_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !final_res |=> rank == $past(rank) + RANK_W'(1))
		else $error("rank did not advance by one");

	a_descending: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !final_res |=> ranked_value <= $past(ranked_value))
		else $error("results not in descending order");

	a_last_reports: assert property (@(posedge clk) disable iff (!arst_n)
		in_last_fire |=> out_valid && rank == '0)
		else $error("last value did not start a result run");

endmodule

bind streaming_top_k_selector_unit tksu_checker u_tksu_checker (.*);
